/* rtl/ramm_pkg.sv */
// ----------------------------------------------------------------------------
// ramm_pkg: shared types, constants and helpers of the arm inertia core
// Fixed-point formats, identified coefficients in Q28, series divisors,
// pipeline latencies and the rounding functions used by several modules.
// ----------------------------------------------------------------------------
package ramm_pkg;

  // Number formats
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int MASS_FRAC_BITS  = 16;
  localparam int IQ              = 28;
  localparam int ANGLE_SHIFT     = IQ - ANGLE_FRAC_BITS;
  localparam int OUT_SHIFT       = IQ - MASS_FRAC_BITS;

  // Port field widths
  localparam int ANGLE_W  = 16;
  localparam int REG_W    = 23;
  localparam int ENTRY_W  = 32;
  localparam int IN_W     = 2 * ANGLE_W;
  localparam int OUT_BITS = 6 * ENTRY_W + 3 * REG_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WRIST_FOUR = 2'd0;
  localparam logic [1:0] REG_WRIST_FIVE = 2'd1;
  localparam logic [1:0] REG_WRIST_SIX  = 2'd2;

  localparam logic [REG_W-1:0] WRIST_FOUR_RESET = 23'd223491;
  localparam logic [REG_W-1:0] WRIST_FIVE_RESET = 23'd213352;
  localparam logic [REG_W-1:0] WRIST_SIX_RESET  = 23'd146807;

  // Angle range reduction
  typedef logic signed [33:0] ang_t;
  localparam ang_t Q_PI      = 34'sd843314857;
  localparam ang_t Q_HALF_PI = 34'sd421657428;
  localparam ang_t Q_TWO_PI  = 34'sd1686629713;

  // Horner datapath: |x| < 2^29, x^2 < 2^30, series terms in [0, 1]
  localparam int HM_BITS = 30;
  typedef logic [28:0]        x_t;
  typedef logic [HM_BITS-1:0] x2_t;
  typedef logic signed [29:0] ht_t;
  typedef logic signed [30:0] trig_t;
  localparam ht_t HQ_ONE = 30'sd268435456;

  localparam int SIN_TERMS = 7;
  localparam int COS_TERMS = 8;
  localparam int SIN_DIV [SIN_TERMS] = '{210, 156, 110, 72, 42, 20, 6};
  localparam int COS_DIV [COS_TERMS] = '{240, 182, 132, 90, 56, 30, 12, 2};

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  // Latency: 3 front stages + 2 per cosine cell, then the matrix pipeline
  localparam int SC_LAT   = 3 + 2 * COS_TERMS;
  localparam int ASM_LAT  = 10;
  localparam int PIPE_LAT = SC_LAT + ASM_LAT;

  // Matrix datapath types
  typedef logic signed [33:0] qop_t;
  typedef logic signed [67:0] qprod_t;
  typedef logic signed [37:0] qsum_t;

  // Decimal to Q28, half up on the magnitude
  localparam logic [63:0] D4  = 64'd625;
  localparam logic [63:0] D7  = 64'd78125;
  localparam logic [63:0] D12 = 64'd244140625;
  localparam logic [63:0] D17 = 64'd762939453125;
  localparam int S4  = IQ - 4;
  localparam int S7  = IQ - 7;
  localparam int S12 = IQ - 12;
  localparam int S17 = IQ - 17;

  localparam logic [63:0] Y0_N  = 64'd290130;
  localparam logic [63:0] Y1_N  = 64'd109085;
  localparam logic [63:0] Y2_N  = 64'd2629;
  localparam logic [63:0] Y3_N  = 64'd26403;
  localparam logic [63:0] Y4_N  = 64'd421;
  localparam logic [63:0] Y5_N  = 64'd509;
  localparam logic [63:0] Y6_N  = 64'd30221;
  localparam logic [63:0] Y7_N  = 64'd24426;
  localparam logic [63:0] Y8_N  = 64'd531;
  localparam logic [63:0] Y9_N  = 64'd2577;
  localparam logic [63:0] Y10_N = 64'd2627;
  localparam logic [63:0] D13_N = 64'd4800;
  localparam logic [63:0] K22_N = 64'd410996935;
  localparam logic [63:0] K23_N = 64'd56321 * 64'd100000000 + 64'd5144118 * 64'd9935;
  localparam logic [63:0] K33_N = 64'd56321 * 64'd10000000000000
                                + 64'd5144118 * 64'd5144118 * 64'd9935;

  localparam logic [63:0] Y0_M  = ((Y0_N / D4) << S4) + ((((Y0_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y1_M  = ((Y1_N / D4) << S4) + ((((Y1_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y2_M  = ((Y2_N / D4) << S4) + ((((Y2_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y3_M  = ((Y3_N / D4) << S4) + ((((Y3_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y4_M  = ((Y4_N / D4) << S4) + ((((Y4_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y5_M  = ((Y5_N / D4) << S4) + ((((Y5_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y6_M  = ((Y6_N / D4) << S4) + ((((Y6_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y7_M  = ((Y7_N / D4) << S4) + ((((Y7_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y8_M  = ((Y8_N / D4) << S4) + ((((Y8_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y9_M  = ((Y9_N / D4) << S4) + ((((Y9_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] Y10_M = ((Y10_N / D4) << S4)
                                + ((((Y10_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] D13_M = ((D13_N / D4) << S4)
                                + ((((D13_N % D4) << S4) + D4 / 2) / D4);
  localparam logic [63:0] K22_M = ((K22_N / D7) << S7)
                                + ((((K22_N % D7) << S7) + D7 / 2) / D7);
  localparam logic [63:0] K23_M = ((K23_N / D12) << S12)
                                + ((((K23_N % D12) << S12) + D12 / 2) / D12);
  localparam logic [63:0] K33_M = ((K33_N / D17) << S17)
                                + ((((K33_N % D17) << S17) + D17 / 2) / D17);

  localparam qsum_t Y0  =  qsum_t'(Y0_M);
  localparam qsum_t Y1  = -qsum_t'(Y1_M);
  localparam qsum_t Y2  = -qsum_t'(Y2_M);
  localparam qsum_t Y3  =  qsum_t'(Y3_M);
  localparam qsum_t Y4  = -qsum_t'(Y4_M);
  localparam qsum_t Y5  =  qsum_t'(Y5_M);
  localparam qsum_t Y6  =  qsum_t'(Y6_M);
  localparam qsum_t Y7  =  qsum_t'(Y7_M);
  localparam qsum_t Y8  =  qsum_t'(Y8_M);
  localparam qsum_t Y9  = -qsum_t'(Y9_M);
  localparam qsum_t Y10 = -qsum_t'(Y10_M);
  localparam qsum_t D13 =  qsum_t'(D13_M);
  localparam qsum_t K22 =  qsum_t'(K22_M);
  localparam qsum_t K23 =  qsum_t'(K23_M);
  localparam qsum_t K33 =  qsum_t'(K33_M);

  // Full product of two Q28 operands
  function automatic qprod_t mulp(qop_t a, qop_t b);
    return qprod_t'(a) * qprod_t'(b);
  endfunction

  // Product back to Q28, half away from zero
  function automatic qsum_t rnd_q(qprod_t p);
    logic [67:0] mag;
    logic [67:0] r;
    mag = p[67] ? 68'(-p) : 68'(p);
    r   = (mag + (68'd1 << (IQ - 1))) >> IQ;
    return p[67] ? -qsum_t'(r[37:0]) : qsum_t'(r[37:0]);
  endfunction

  // Q28 to the output format, half away from zero, saturated
  function automatic logic [ENTRY_W-1:0] to_out(qsum_t v);
    logic signed [38:0] vx;
    logic [38:0]        mag;
    logic [38:0]        m;
    logic [ENTRY_W-1:0] r;
    vx  = 39'(v);
    mag = vx[38] ? 39'(-vx) : 39'(vx);
    m   = (mag + (39'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (vx[38]) begin
      r = (m > 39'd2147483648) ? 32'h8000_0000 : 32'(-m);
    end else begin
      r = (m > 39'd2147483647) ? 32'h7fff_ffff : 32'(m);
    end
    return r;
  endfunction

endpackage

/* rtl/ramm_cell.sv */
// ----------------------------------------------------------------------------
// ramm_cell: one Horner step of a sine or cosine series
// t_out = 1 - floor(round(x2 * t_in) / DIV), two register stages. The
// constant divide is a reciprocal multiply that is exact for x2 * t < 2^30.
// ----------------------------------------------------------------------------
module ramm_cell
  import ramm_pkg::*;
#(
  parameter int DIV    = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  x2_t               x2_in,
  input  ht_t               t_in,
  input  logic [SIDE_W-1:0] side_in,
  output x2_t               x2_out,
  output ht_t               t_out,
  output logic [SIDE_W-1:0] side_out
);

  localparam int LOG_DIV = $clog2(DIV);
  localparam int SH      = HM_BITS + LOG_DIV;
  localparam logic [63:0] RECIP_W = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [HM_BITS:0] RECIP = RECIP_W[HM_BITS:0];
  localparam int PROD_W = HM_BITS + IQ + 1;
  localparam int QF_W   = 2 * HM_BITS + 1;

  logic [PROD_W-1:0] prod;
  x2_t               x2_d1;
  logic [SIDE_W-1:0] side_d1;
  logic [HM_BITS-1:0] m;
  logic [QF_W-1:0]   qf;
  x2_t               x2_d2;
  logic [SIDE_W-1:0] side_d2;

  // stage 1: x2 * t
  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= PROD_W'(x2_in) * PROD_W'(t_in[IQ:0]);
      x2_d1   <= x2_in;
      side_d1 <= side_in;
    end
  end

  // stage 2: round to Q28, multiply by the reciprocal
  assign m = HM_BITS'((prod + (PROD_W'(1) << (IQ - 1))) >> IQ);

  always_ff @(posedge clk) begin
    if (en) begin
      qf      <= QF_W'(m) * QF_W'(RECIP);
      x2_d2   <= x2_d1;
      side_d2 <= side_d1;
    end
  end

  assign t_out    = HQ_ONE - ht_t'(qf >> SH);
  assign x2_out   = x2_d2;
  assign side_out = side_d2;

endmodule

/* rtl/ramm_sincos.sv */
// ----------------------------------------------------------------------------
// ramm_sincos: sine and cosine of one angle
// Range reduction and folding, x^2, then a chain of Horner cells for each
// series. Every register advances only while en is high.
// ----------------------------------------------------------------------------
module ramm_sincos
  import ramm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] angle,
  output sc_t                trig
);

  ang_t  a_ext;
  ang_t  a_wrap;
  ang_t  a_w;
  ang_t  f;
  logic  f_cneg;
  x_t    x;
  logic  sneg;
  logic  cneg;
  logic [57:0] sq;
  x_t    x_d;
  logic  sneg_d;
  logic  cneg_d;
  x2_t   x2;

  x2_t   sx2 [SIN_TERMS];
  ht_t   st  [SIN_TERMS+1];
  logic [29:0] sside [SIN_TERMS+1];
  x2_t   cx2 [COS_TERMS];
  ht_t   ct  [COS_TERMS+1];
  logic [0:0] cside [COS_TERMS+1];

  logic [57:0] sp;
  logic        sp_neg;
  logic [30:0] s_mag;
  trig_t       s_out;
  ht_t         c_clamp;

  // front: scale to Q28 and wrap into [-pi, pi]
  always_comb begin
    a_ext = ang_t'(signed'({angle, {ANGLE_SHIFT{1'b0}}}));
    if (a_ext > Q_PI) begin
      a_wrap = a_ext - Q_TWO_PI;
    end else if (a_ext < -Q_PI) begin
      a_wrap = a_ext + Q_TWO_PI;
    end else begin
      a_wrap = a_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_w <= a_wrap;
    end
  end

  // fold into [-pi/2, pi/2]
  always_comb begin
    if (a_w > Q_HALF_PI) begin
      f      = Q_PI - a_w;
      f_cneg = 1'b1;
    end else if (a_w < -Q_HALF_PI) begin
      f      = -Q_PI - a_w;
      f_cneg = 1'b1;
    end else begin
      f      = a_w;
      f_cneg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_t'(f[33] ? -f : f);
      sneg <= f[33];
      cneg <= f_cneg;
    end
  end

  // square
  always_ff @(posedge clk) begin
    if (en) begin
      sq     <= 58'(x) * 58'(x);
      x_d    <= x;
      sneg_d <= sneg;
      cneg_d <= cneg;
    end
  end

  assign x2 = x2_t'((sq + (58'd1 << (IQ - 1))) >> IQ);

  // sine series
  assign sx2[0]   = x2;
  assign st[0]    = HQ_ONE;
  assign sside[0] = {sneg_d, x_d};

  for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
    if (i == SIN_TERMS - 1) begin : g_end
      ramm_cell #(.DIV(SIN_DIV[i]), .SIDE_W(30)) u_cell (
        .clk, .en,
        .x2_in(sx2[i]), .t_in(st[i]), .side_in(sside[i]),
        .x2_out(), .t_out(st[i+1]), .side_out(sside[i+1])
      );
    end else begin : g_mid
      ramm_cell #(.DIV(SIN_DIV[i]), .SIDE_W(30)) u_cell (
        .clk, .en,
        .x2_in(sx2[i]), .t_in(st[i]), .side_in(sside[i]),
        .x2_out(sx2[i+1]), .t_out(st[i+1]), .side_out(sside[i+1])
      );
    end
  end

  // cosine series
  assign cx2[0]   = x2;
  assign ct[0]    = HQ_ONE;
  assign cside[0] = cneg_d;

  for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
    if (i == COS_TERMS - 1) begin : g_end
      ramm_cell #(.DIV(COS_DIV[i]), .SIDE_W(1)) u_cell (
        .clk, .en,
        .x2_in(cx2[i]), .t_in(ct[i]), .side_in(cside[i]),
        .x2_out(), .t_out(ct[i+1]), .side_out(cside[i+1])
      );
    end else begin : g_mid
      ramm_cell #(.DIV(COS_DIV[i]), .SIDE_W(1)) u_cell (
        .clk, .en,
        .x2_in(cx2[i]), .t_in(ct[i]), .side_in(cside[i]),
        .x2_out(cx2[i+1]), .t_out(ct[i+1]), .side_out(cside[i+1])
      );
    end
  end

  // sine: x * series, two stages to line up with the longer cosine chain
  always_ff @(posedge clk) begin
    if (en) begin
      sp     <= 58'(sside[SIN_TERMS][28:0]) * 58'(st[SIN_TERMS][IQ:0]);
      sp_neg <= sside[SIN_TERMS][29];
    end
  end

  assign s_mag = 31'((sp + (58'd1 << (IQ - 1))) >> IQ);

  always_ff @(posedge clk) begin
    if (en) begin
      s_out <= sp_neg ? -trig_t'(s_mag) : trig_t'(s_mag);
    end
  end

  // cosine: clamp at zero, sign from the fold
  assign c_clamp = ct[COS_TERMS][29] ? '0 : ct[COS_TERMS];
  assign trig.s  = s_out;
  assign trig.c  = cside[COS_TERMS][0] ? -trig_t'(c_clamp) : trig_t'(c_clamp);

endmodule

/* rtl/ramm_assemble.sv */
// ----------------------------------------------------------------------------
// ramm_assemble: inertia entries from the trig terms
// Ten-stage multiply / round / sum pipeline over the closed-form matrix,
// with rounded and saturated outputs, registered but for mass_three_three.
// ----------------------------------------------------------------------------
module ramm_assemble
  import ramm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  sc_t                sc1,
  input  sc_t                sc2,
  input  sc_t                sc12,
  output logic [ENTRY_W-1:0] mass_one_one,
  output logic [ENTRY_W-1:0] mass_one_two,
  output logic [ENTRY_W-1:0] mass_one_three,
  output logic [ENTRY_W-1:0] mass_two_two,
  output logic [ENTRY_W-1:0] mass_two_three,
  output logic [ENTRY_W-1:0] mass_three_three
);

  // P1 products
  qprod_t p_c1c1, p_s1s1, p_c1s1, p_s12s12, p_c12c12, p_s12c12;
  qprod_t p_ds, p_dc, p_c1y3, p_s1y4, p_s12y9, p_c12y10;
  // P2 rounded
  qsum_t r_c1c1, r_s1s1, r_c1s1, r_s12s12, r_c12c12, r_s12c12;
  qsum_t r_ds, r_dc, r_c1y3, r_s1y4, r_s12y9, r_c12y10;
  // P3 terms
  qsum_t ca, sb, dif, prd, ds3, dc3, t13, e3;
  // P4 products
  qprod_t p_dsdif, p_dcprd, p_dsprd, p_dcdif, p_cay1, p_sby2, p_dify7, p_prdy8;
  qprod_t p_dsy5, p_dcy6;
  qsum_t  ds4, dc4, t13_4, e4;
  // P5 rounded
  qsum_t r_dsdif, r_dcprd, r_dsprd, r_dcdif, r_cay1, r_sby2, r_dify7, r_prdy8;
  qsum_t r_dsy5, r_dcy6;
  qsum_t ds5, dc5, t13_5, e5;
  // P6 sums
  qsum_t p5, p6, part6, g6, o12_6, e6;
  // P7 products
  qprod_t p_p5y5, p_p6y6;
  qsum_t  part7, g7, o12_7, e7;
  // P8 rounded
  qsum_t r_p5y5, r_p6y6, part8, g8, o12_8, e8;
  // P9 final sums
  qsum_t m11, v22, v23, o12_9, e9;

  always_ff @(posedge clk) begin
    if (en) begin
      // P1
      p_c1c1   <= mulp(qop_t'(sc1.c), qop_t'(sc1.c));
      p_s1s1   <= mulp(qop_t'(sc1.s), qop_t'(sc1.s));
      p_c1s1   <= mulp(qop_t'(sc1.c), qop_t'(sc1.s));
      p_s12s12 <= mulp(qop_t'(sc12.s), qop_t'(sc12.s));
      p_c12c12 <= mulp(qop_t'(sc12.c), qop_t'(sc12.c));
      p_s12c12 <= mulp(qop_t'(sc12.s), qop_t'(sc12.c));
      p_ds     <= mulp(qop_t'(D13), qop_t'(sc2.s));
      p_dc     <= mulp(qop_t'(D13), qop_t'(sc2.c));
      p_c1y3   <= mulp(qop_t'(sc1.c), qop_t'(Y3));
      p_s1y4   <= mulp(qop_t'(sc1.s), qop_t'(Y4));
      p_s12y9  <= mulp(qop_t'(sc12.s), qop_t'(Y9));
      p_c12y10 <= mulp(qop_t'(sc12.c), qop_t'(Y10));
      // P2
      r_c1c1   <= rnd_q(p_c1c1);
      r_s1s1   <= rnd_q(p_s1s1);
      r_c1s1   <= rnd_q(p_c1s1);
      r_s12s12 <= rnd_q(p_s12s12);
      r_c12c12 <= rnd_q(p_c12c12);
      r_s12c12 <= rnd_q(p_s12c12);
      r_ds     <= rnd_q(p_ds);
      r_dc     <= rnd_q(p_dc);
      r_c1y3   <= rnd_q(p_c1y3);
      r_s1y4   <= rnd_q(p_s1y4);
      r_s12y9  <= rnd_q(p_s12y9);
      r_c12y10 <= rnd_q(p_c12y10);
      // P3
      ca  <= r_c1c1 - r_s1s1;
      sb  <= r_c1s1 + r_c1s1;
      dif <= r_s12s12 - r_c12c12;
      prd <= r_s12c12;
      ds3 <= r_ds;
      dc3 <= r_dc;
      t13 <= r_c1y3 - r_s1y4;
      e3  <= r_s12y9 + r_c12y10;
      // P4
      p_dsdif <= mulp(qop_t'(ds3), qop_t'(dif));
      p_dcprd <= mulp(qop_t'(dc3), qop_t'(prd));
      p_dsprd <= mulp(qop_t'(ds3), qop_t'(prd));
      p_dcdif <= mulp(qop_t'(dc3), qop_t'(dif));
      p_cay1  <= mulp(qop_t'(ca), qop_t'(Y1));
      p_sby2  <= mulp(qop_t'(sb), qop_t'(Y2));
      p_dify7 <= mulp(qop_t'(dif), qop_t'(Y7));
      p_prdy8 <= mulp(qop_t'(prd), qop_t'(Y8));
      p_dsy5  <= mulp(qop_t'(ds3), qop_t'(Y5));
      p_dcy6  <= mulp(qop_t'(dc3), qop_t'(Y6));
      ds4     <= ds3;
      dc4     <= dc3;
      t13_4   <= t13;
      e4      <= e3;
      // P5
      r_dsdif <= rnd_q(p_dsdif);
      r_dcprd <= rnd_q(p_dcprd);
      r_dsprd <= rnd_q(p_dsprd);
      r_dcdif <= rnd_q(p_dcdif);
      r_cay1  <= rnd_q(p_cay1);
      r_sby2  <= rnd_q(p_sby2);
      r_dify7 <= rnd_q(p_dify7);
      r_prdy8 <= rnd_q(p_prdy8);
      r_dsy5  <= rnd_q(p_dsy5);
      r_dcy6  <= rnd_q(p_dcy6);
      ds5     <= ds4;
      dc5     <= dc4;
      t13_5   <= t13_4;
      e5      <= e4;
      // P6
      p5    <= ds5 - r_dsdif - r_dcprd - r_dcprd;
      p6    <= dc5 - r_dsprd - r_dsprd + r_dcdif;
      part6 <= Y0 + r_cay1 - r_sby2 + r_dify7 + r_prdy8 + r_prdy8;
      g6    <= r_dsy5 + r_dcy6;
      o12_6 <= t13_5 + e5;
      e6    <= e5;
      // P7
      p_p5y5 <= mulp(qop_t'(p5), qop_t'(Y5));
      p_p6y6 <= mulp(qop_t'(p6), qop_t'(Y6));
      part7  <= part6;
      g7     <= g6;
      o12_7  <= o12_6;
      e7     <= e6;
      // P8
      r_p5y5 <= rnd_q(p_p5y5);
      r_p6y6 <= rnd_q(p_p6y6);
      part8  <= part7;
      g8     <= g7;
      o12_8  <= o12_7;
      e8     <= e7;
      // P9
      m11   <= part8 + r_p5y5 + r_p6y6;
      v22   <= g8 + g8 + K22;
      v23   <= g8 + K23;
      o12_9 <= o12_8;
      e9    <= e8;
      // P10: output register
      mass_one_one   <= to_out(m11);
      mass_one_two   <= to_out(o12_9);
      mass_one_three <= to_out(e9);
      mass_two_two   <= to_out(v22);
      mass_two_three <= to_out(v23);
    end
  end

  // the elbow diagonal is a constant of the arm
  assign mass_three_three = to_out(K33);

endmodule

/* rtl/robot_arm_mass_matrix_core.sv */
// ----------------------------------------------------------------------------
// robot_arm_mass_matrix_core: joint inertia matrix of a six-axis arm
// Angle pair in, the nine distinct nonzero inertia entries out.
// ----------------------------------------------------------------------------
// The core accepts one angle pair per clock and returns one set of entries per
// pair, in order. The latency is set by the sine/cosine cell chains (three
// front stages plus two stages per cosine series term, eight terms) and the
// ten-stage multiply/round pipeline that assembles the matrix. The whole
// pipeline advances together; it holds only while a finished result waits
// on m_tready. The wrist entries are the configuration registers, which
// should be written while no transaction is in flight.
module robot_arm_mass_matrix_core
  import ramm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // shoulder_angle, elbow_angle
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // mass_one_one, mass_one_two,
                                        // mass_one_three, mass_two_two,
                                        // mass_two_three, mass_three_three,
                                        // mass_four_four, mass_five_five,
                                        // mass_six_six, zero pad
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  logic                 en;
  logic [PIPE_LAT-1:0]  vld;
  logic signed [16:0]   q1;
  logic signed [16:0]   q2;
  logic signed [16:0]   q12;
  sc_t                  sc1;
  sc_t                  sc2;
  sc_t                  sc12;
  logic [REG_W-1:0]     wrist_four;
  logic [REG_W-1:0]     wrist_five;
  logic [REG_W-1:0]     wrist_six;
  logic [ENTRY_W-1:0]   e11, e12, e13, e22, e23, e33;

  // pipeline moves unless the output holds an untaken result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], s_tvalid};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wrist_four <= WRIST_FOUR_RESET;
      wrist_five <= WRIST_FIVE_RESET;
      wrist_six  <= WRIST_SIX_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WRIST_FOUR: wrist_four <= cfg_data;
        REG_WRIST_FIVE: wrist_five <= cfg_data;
        REG_WRIST_SIX:  wrist_six  <= cfg_data;
        default: ;
      endcase
    end
  end

  // joint angles and their sum
  assign q1  = 17'(signed'(s_tdata[ANGLE_W-1:0]));
  assign q2  = 17'(signed'(s_tdata[IN_W-1:ANGLE_W]));
  assign q12 = q1 + q2;

  ramm_sincos u_sc1  (.clk, .en, .angle(q1),  .trig(sc1));
  ramm_sincos u_sc2  (.clk, .en, .angle(q2),  .trig(sc2));
  ramm_sincos u_sc12 (.clk, .en, .angle(q12), .trig(sc12));

  ramm_assemble u_asm (
    .clk, .en,
    .sc1, .sc2, .sc12,
    .mass_one_one(e11), .mass_one_two(e12), .mass_one_three(e13),
    .mass_two_two(e22), .mass_two_three(e23), .mass_three_three(e33)
  );

  assign m_tdata = {(OUT_W - OUT_BITS)'(0), wrist_six, wrist_five, wrist_four,
                    e33, e23, e22, e13, e12, e11};

  // a held result stalls the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

  // an accepted transaction enters the valid pipe
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted transaction lost at pipeline entry");

  // a stall freezes every in-flight transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during stall");

  // reset loads the wrist defaults
  a_cfg_rst: assert property (@(posedge clk)
    rst |=> (wrist_four == WRIST_FOUR_RESET && wrist_five == WRIST_FIVE_RESET &&
             wrist_six == WRIST_SIX_RESET))
    else $error("wrist registers not at reset value");

endmodule
